### rtl/assert_macros.svh
// Assertion helpers, clocked on clock, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rse_pkg.sv
package rse_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int RATING_MAX      = 50;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_LOOKUP = 3'd2;
   localparam logic [2:0] OP_UPDATE = 3'd3;
   localparam logic [2:0] OP_SORT   = 3'd4;
   localparam logic [2:0] OP_LIST   = 3'd5;

   localparam logic [1:0] SF_RATING = 2'd0;
   localparam logic [1:0] SF_PRICE  = 2'd1;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_EMPTY      = 3'd3;
   localparam logic [2:0] ST_BAD_RATING = 3'd4;
   localparam logic [2:0] ST_BAD_SORT   = 3'd5;
   localparam logic [2:0] ST_BAD_OP     = 3'd6;

   typedef struct packed {
      logic signed [31:0] id;
      logic [23:0]        price;
      logic [5:0]         rating;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [1:0] {WR_INS, WR_UPD, WR_RAM, WR_HOLD} wr_src_type;

   typedef enum logic [2:0] {SRC_NONE, SRC_INS, SRC_UPD, SRC_RAM, SRC_HOLD} out_src_type;

   typedef struct packed {
      logic        cap;
      logic        rd_en;
      logic        wr_en;
      wr_src_type  wr_src;
      logic        hold_ld;
      logic        out_ld;
      out_src_type out_src;
      logic [2:0]  out_status;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] sf;
      logic       rating_bad;
      logic       match;
      logic       swap;
      logic       out_free;
   } sts_type;

endpackage

### rtl/rse_ram.sv
module rse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rse_datapath.sv
module rse_datapath #(
   parameter int TABLE_DEPTH = rse_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [4:0]                     req_tuser,
   input  logic [95:0]                    req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,
   output logic [2:0]                     rsp_tuser,
   output logic                           rsp_tlast,
   input  rse_pkg::cmd_type               cmd,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   output rse_pkg::sts_type               sts
);

   logic [2:0]       op_ff;
   logic [1:0]       sf_ff;
   logic [31:0]      key_ff, nid_ff;
   logic [23:0]      price_ff;
   logic [7:0]       rating_ff;
   rse_pkg::rec_type hold_ff;
   rse_pkg::rec_type out_rec_ff, out_rec_in;
   logic [2:0]       out_status_ff;
   logic             out_last_ff;
   logic             out_valid_ff;
   rse_pkg::rec_type rdata, wdata, ins_rec, upd_rec;
   logic [rse_pkg::REC_W-1:0] rdata_raw;

   assign ins_rec = '{id: key_ff, price: price_ff, rating: rating_ff[5:0]};
   assign upd_rec = '{id: nid_ff, price: price_ff, rating: rating_ff[5:0]};
   assign rdata   = rse_pkg::rec_type'(rdata_raw);

   always_comb begin
      case (cmd.wr_src)
         rse_pkg::WR_INS: wdata = ins_rec;
         rse_pkg::WR_UPD: wdata = upd_rec;
         rse_pkg::WR_RAM: wdata = rdata;
         default:         wdata = hold_ff;
      endcase
   end

   always_comb begin
      case (cmd.out_src)
         rse_pkg::SRC_INS:  out_rec_in = ins_rec;
         rse_pkg::SRC_UPD:  out_rec_in = upd_rec;
         rse_pkg::SRC_RAM:  out_rec_in = rdata;
         rse_pkg::SRC_HOLD: out_rec_in = hold_ff;
         default:           out_rec_in = '0;
      endcase
   end

   rse_ram #(.WIDTH(rse_pkg::REC_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rdata_raw)
   );

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         op_ff     <= req_tuser[2:0];
         sf_ff     <= req_tuser[4:3];
         key_ff    <= req_tdata[31:0];
         nid_ff    <= req_tdata[63:32];
         price_ff  <= req_tdata[87:64];
         rating_ff <= req_tdata[95:88];
      end
      if (cmd.hold_ld) begin
         hold_ff <= rdata;
      end
      if (cmd.out_ld) begin
         out_rec_ff    <= out_rec_in;
         out_status_ff <= cmd.out_status;
         out_last_ff   <= cmd.out_last;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign sts.op         = op_ff;
   assign sts.sf         = sf_ff;
   assign sts.rating_bad = rating_ff > 8'(rse_pkg::RATING_MAX);
   assign sts.match      = rdata.id == key_ff;
   assign sts.swap       = (sf_ff == rse_pkg::SF_PRICE) ? (hold_ff.price < rdata.price)
                                                        : (hold_ff.rating < rdata.rating);
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_rec_ff.rating, out_rec_ff.price, out_rec_ff.id};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### rtl/rse_ctrl.sv
module rse_ctrl #(
   parameter int TABLE_DEPTH = rse_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  rse_pkg::sts_type               sts,
   output rse_pkg::cmd_type               cmd,
   output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SRCH_RD, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR,
      S_SORT_LDI, S_SORT_HLD, S_SORT_RDJ, S_SORT_CMP, S_SORT_WRI,
      S_LIST_RD, S_LIST_EMIT, S_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            i_ff, i_in, j_ff, j_in;
   logic [2:0]               em_status_ff, em_status_in;
   rse_pkg::out_src_type     em_src_ff, em_src_in;
   logic [CW-1:0]            i_inc, j_inc;

   assign i_inc = CW'(i_ff + 1'b1);
   assign j_inc = CW'(j_ff + 1'b1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      em_status_in = em_status_ff;
      em_src_in    = em_src_ff;
      cmd          = '0;
      rd_addr      = '0;
      wr_addr      = '0;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.cap  = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in  = S_EMIT;
            em_src_in = rse_pkg::SRC_NONE;
            if (sts.op > rse_pkg::OP_LIST) begin
               em_status_in = rse_pkg::ST_BAD_OP;
            end else if (sts.op == rse_pkg::OP_INSERT) begin
               if (sts.rating_bad) begin
                  em_status_in = rse_pkg::ST_BAD_RATING;
               end else if (count_ff == CW'(TABLE_DEPTH)) begin
                  em_status_in = rse_pkg::ST_FULL;
               end else begin
                  cmd.wr_en    = 1'b1;
                  cmd.wr_src   = rse_pkg::WR_INS;
                  wr_addr      = count_ff[AW-1:0];
                  count_in     = CW'(count_ff + 1'b1);
                  em_status_in = rse_pkg::ST_OK;
                  em_src_in    = rse_pkg::SRC_INS;
               end
            end else if (count_ff == '0) begin
               em_status_in = rse_pkg::ST_EMPTY;
            end else if (sts.op == rse_pkg::OP_SORT && sts.sf > rse_pkg::SF_PRICE) begin
               em_status_in = rse_pkg::ST_BAD_SORT;
            end else if (sts.op == rse_pkg::OP_SORT) begin
               i_in     = '0;
               state_in = (count_ff < CW'(2)) ? S_LIST_RD : S_SORT_LDI;
            end else if (sts.op == rse_pkg::OP_LIST) begin
               i_in     = '0;
               state_in = S_LIST_RD;
            end else begin
               j_in     = '0;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = j_ff[AW-1:0];
            state_in  = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (sts.match) begin
               state_in     = S_EMIT;
               em_status_in = rse_pkg::ST_OK;
               em_src_in    = rse_pkg::SRC_RAM;
               if (sts.op == rse_pkg::OP_REMOVE) begin
                  cmd.hold_ld = 1'b1;
                  i_in        = j_ff;
                  state_in    = S_SHIFT_RD;
               end else if (sts.op == rse_pkg::OP_UPDATE) begin
                  if (sts.rating_bad) begin
                     em_status_in = rse_pkg::ST_BAD_RATING;
                     em_src_in    = rse_pkg::SRC_NONE;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_src = rse_pkg::WR_UPD;
                     wr_addr    = j_ff[AW-1:0];
                     em_src_in  = rse_pkg::SRC_UPD;
                  end
               end
            end else if (j_inc == count_ff) begin
               em_status_in = rse_pkg::ST_NOT_FOUND;
               em_src_in    = rse_pkg::SRC_NONE;
               state_in     = S_EMIT;
            end else begin
               j_in     = j_inc;
               state_in = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: begin
            if (i_inc < count_ff) begin
               cmd.rd_en = 1'b1;
               rd_addr   = i_inc[AW-1:0];
               state_in  = S_SHIFT_WR;
            end else begin
               count_in     = CW'(count_ff - 1'b1);
               em_status_in = rse_pkg::ST_OK;
               em_src_in    = rse_pkg::SRC_HOLD;
               state_in     = S_EMIT;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = rse_pkg::WR_RAM;
            wr_addr    = i_ff[AW-1:0];
            i_in       = i_inc;
            state_in   = S_SHIFT_RD;
         end
         S_SORT_LDI: begin
            cmd.rd_en = 1'b1;
            rd_addr   = i_ff[AW-1:0];
            state_in  = S_SORT_HLD;
         end
         S_SORT_HLD: begin
            cmd.hold_ld = 1'b1;
            j_in        = i_inc;
            state_in    = S_SORT_RDJ;
         end
         S_SORT_RDJ: begin
            cmd.rd_en = 1'b1;
            rd_addr   = j_ff[AW-1:0];
            state_in  = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            // entry i lives in the hold register during the inner pass
            if (sts.swap) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_src  = rse_pkg::WR_HOLD;
               wr_addr     = j_ff[AW-1:0];
               cmd.hold_ld = 1'b1;
            end
            if (j_inc == count_ff) begin
               state_in = S_SORT_WRI;
            end else begin
               j_in     = j_inc;
               state_in = S_SORT_RDJ;
            end
         end
         S_SORT_WRI: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = rse_pkg::WR_HOLD;
            wr_addr    = i_ff[AW-1:0];
            if (CW'(i_ff + 2'd2) == count_ff) begin
               i_in     = '0;
               state_in = S_LIST_RD;
            end else begin
               i_in     = i_inc;
               state_in = S_SORT_LDI;
            end
         end
         S_LIST_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = i_ff[AW-1:0];
            state_in  = S_LIST_EMIT;
         end
         S_LIST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_ld     = 1'b1;
               cmd.out_src    = rse_pkg::SRC_RAM;
               cmd.out_status = rse_pkg::ST_OK;
               cmd.out_last   = i_inc == count_ff;
               i_in           = i_inc;
               state_in       = (i_inc == count_ff) ? S_IDLE : S_LIST_RD;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.out_ld     = 1'b1;
               cmd.out_src    = em_src_ff;
               cmd.out_status = em_status_ff;
               cmd.out_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         em_status_ff <= rse_pkg::ST_OK;
         em_src_ff    <= rse_pkg::SRC_NONE;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         em_status_ff <= em_status_in;
         em_src_ff    <= em_src_in;
      end
   end

endmodule

### rtl/record_table_sort_engine.sv
// One item at a time. Insert and error answers: captured, dispatched, then registered by
// the emit state; next transfer taken in idle. Lookup/update: read and compare per entry
// walked; remove adds read and write per entry shifted down. Sort: read and compare per
// exchange-sort compare (n(n-1)/2), load, hold and write-back per outer pass; list: read
// and emit per record. A stalled result holds the engine in its emit states until taken.
// Reset clears the record count and the control; the RAM is not cleared.
`include "assert_macros.svh"

module record_table_sort_engine #(
   parameter int TABLE_DEPTH = rse_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // key_id, new_id, price_cents, rating_tenths
   input  logic [4:0]  req_tuser,  // op, sort_field
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // rec_id, rec_price, rec_rating, zero pad
   output logic [2:0]  rsp_tuser,  // status
   output logic        rsp_tlast
);

   rse_pkg::cmd_type               cmd;
   rse_pkg::sts_type               sts;
   logic [$clog2(TABLE_DEPTH)-1:0] rd_addr, wr_addr;
   logic                           rsp_err;

   rse_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr)
   );

   rse_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .sts        (sts)
   );

   assign rsp_err = rsp_tvalid && rsp_tuser != rse_pkg::ST_OK;

   `ASSERT_IMPLIES(a_err_no_record, rsp_err, rsp_tdata == 64'd0, "error result carries a record")
   `ASSERT_IMPLIES(a_err_is_last, rsp_err, rsp_tlast, "error result not last")
   `ASSERT_IMPLIES(a_rating_range, rsp_tvalid, rsp_tdata[61:56] <= 6'd50, "rating out of range")
   `ASSERT_NEXT(a_single_item, req_tvalid && req_tready, !req_tready, "item taken while busy")

endmodule
